### design/scf_pkg.sv
// Shared types and constants of the serial color command framer.
package scf_pkg;

    // Packet layout: header, command, five value bytes, checksum
    localparam int PACKET_BYTES = 8;
    localparam int STORE_DEPTH  = PACKET_BYTES - 2;
    localparam int COUNT_W      = $clog2(PACKET_BYTES);

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [7:0]         t_byte;

    localparam t_count LAST_IDX     = t_count'(PACKET_BYTES - 1);
    localparam t_byte  HEADER_RESET = 8'hA5;

    // Command byte codes
    localparam t_byte CMD_SET     = 8'h01;
    localparam t_byte CMD_RELEASE = 8'h02;

    // Result command codes
    localparam logic RES_SET     = 1'b0;
    localparam logic RES_RELEASE = 1'b1;

    typedef struct packed {
        logic  command;
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte white;
        t_byte brightness;
        logic  control_held;
    } t_result;

endpackage

### design/scf_parser.sv
// Packet parser: byte count, running checksum, packet bytes and control flag.
module scf_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  scf_pkg::t_byte i_byte,
    input  scf_pkg::t_byte i_header,
    output logic          o_res_valid,
    output scf_pkg::t_result o_result
);
    import scf_pkg::*;

    t_count r_count, n_count;
    t_byte  r_xor, n_xor;
    logic   r_control, n_control;
    t_byte  r_store [STORE_DEPTH];

    // Decode the current word against the packet state
    always_comb begin
        n_count     = r_count;
        n_xor       = r_xor;
        n_control   = r_control;
        o_res_valid = 1'b0;
        o_result    = '0;
        priority if (r_count == '0) begin
            // hunt for header, drop anything else
            if (i_byte == i_header) begin
                n_xor   = i_byte;
                n_count = t_count'(1);
            end
        end else if (r_count != LAST_IDX) begin
            n_xor   = r_xor ^ i_byte;
            n_count = r_count + t_count'(1);
        end else begin
            // checksum word closes the packet
            n_count = '0;
            n_xor   = '0;
            if (i_byte == r_xor) begin
                if (r_store[0] == CMD_SET) begin
                    n_control             = 1'b1;
                    o_res_valid           = 1'b1;
                    o_result.command      = RES_SET;
                    o_result.red          = r_store[1];
                    o_result.green        = r_store[2];
                    o_result.blue         = r_store[3];
                    o_result.white        = r_store[4];
                    o_result.brightness   = r_store[5];
                    o_result.control_held = 1'b1;
                end else if (r_store[0] == CMD_RELEASE) begin
                    n_control             = 1'b0;
                    o_res_valid           = 1'b1;
                    o_result.command      = RES_RELEASE;
                    o_result.control_held = 1'b0;
                end
            end
        end
    end

    // Advance packet state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_xor     <= '0;
            r_control <= 1'b0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_xor     <= n_xor;
            r_control <= n_control;
        end
    end

    // Capture command and value bytes by position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (i_step && r_count == t_count'(k + 1)) begin
                r_store[k] <= i_byte;
            end
        end
    end

endmodule

### design/serial_color_command_framer.sv
// Top level of the serial color command framer.
//
// Input channel: one received serial word per handshake on i_rx_byte
// (i_in_valid / o_in_stall). Words outside a packet that differ from the
// header register are dropped. A packet is eight words: header, command,
// red, green, blue, white, brightness and an XOR checksum of the first seven.
// Output channel: a result word (o_out_valid / i_out_stall) appears only when
// a packet closes with a good checksum and a set or release command.
// Config channel: i_cfg_valid / o_cfg_ready writes the header byte; ready is
// always high. Write it only while no packet is in flight.
// Path: a word accepted into the input register is parsed from there into the
// output register, where its result can be taken.
// Throughput: one word per cycle while the output is not stalled; the parser is a
// single stage between the input register and the output register.
// Stall: while a result waits, one more word is still taken if the input
// register is empty; further input stalls until the result is taken.
// Reset (synchronous, active low): empties both registers, clears the packet
// count, checksum and control flag, and loads the header byte with 0xA5.
module serial_color_command_framer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  scf_pkg::t_byte i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  scf_pkg::t_byte i_rx_byte,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_command,
    output scf_pkg::t_byte o_red,
    output scf_pkg::t_byte o_green,
    output scf_pkg::t_byte o_blue,
    output scf_pkg::t_byte o_white,
    output scf_pkg::t_byte o_brightness,
    output logic          o_control_held
);
    import scf_pkg::*;

    t_byte   r_header;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    step;
    logic    res_valid;
    t_result result;

    assign o_cfg_ready = 1'b1;

    // Hold the header byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_header <= i_cfg_data;
        end
    end

    // Output register can load when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_header   (r_header),
        .o_res_valid(res_valid),
        .o_result   (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command      = r_out.command;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_white        = r_out.white;
    assign o_brightness   = r_out.brightness;
    assign o_control_held = r_out.control_held;

endmodule

### design/scf_checker.sv
// Port-level checker for the serial color command framer, with its bind.
module scf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic          o_command,
    input scf_pkg::t_byte o_red,
    input scf_pkg::t_byte o_green,
    input scf_pkg::t_byte o_blue,
    input scf_pkg::t_byte o_white,
    input scf_pkg::t_byte o_brightness,
    input logic          o_control_held
);
    import scf_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Release result carries zero levels and no control
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command == RES_RELEASE |->
            o_red == '0 && o_green == '0 && o_blue == '0 && o_white == '0 &&
            o_brightness == '0 && !o_control_held)
        else $error("release result carries nonzero fields");

    // Set result always grants control
    a_set_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command == RES_SET |-> o_control_held)
        else $error("set result without control held");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind serial_color_command_framer scf_checker u_scf_checker (.*);

### tb/sv/tb_serial_color_command_framer.sv
// Testbench: serial color command framer, directed packet table then random framed traffic.
`timescale 1ns / 100ps

module tb_serial_color_command_framer;
    import scf_pkg::*;

    localparam int WORDS_PER_PHASE = 320;
    localparam int PHASES          = 5;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 2000;

    // One row of the directed table: a word, and where "fixed" is set,
    // the result that the closing checksum word must produce.
    typedef struct packed {
        t_byte   word;
        logic    fixed;
        t_result want;
    } t_row;

    localparam t_result NO_RESULT      = '0;
    localparam t_result RELEASE_RESULT = {RES_RELEASE, 40'h0, 1'b0};
    localparam t_result SET_FF_RESULT  = {RES_SET, {5{8'hFF}}, 1'b1};

    localparam int SCRIPT_LEN = 33;
    localparam t_row SCRIPT [SCRIPT_LEN] = '{
        // stray word outside a packet, dropped
        {8'hFF, 1'b0, NO_RESULT},
        // release right after reset, value bytes at full scale are ignored
        {8'hA5, 1'b0, NO_RESULT}, {8'h02, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'h58, 1'b1, RELEASE_RESULT},
        // set color with every level at full scale
        {8'hA5, 1'b0, NO_RESULT}, {8'h01, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT}, {8'h5B, 1'b1, SET_FF_RESULT},
        // set color with a bad checksum
        {8'hA5, 1'b0, NO_RESULT}, {8'h01, 1'b0, NO_RESULT},
        {8'h12, 1'b0, NO_RESULT}, {8'h34, 1'b0, NO_RESULT},
        {8'h56, 1'b0, NO_RESULT}, {8'h78, 1'b0, NO_RESULT},
        {8'h9A, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        // unknown command with a good checksum
        {8'hA5, 1'b0, NO_RESULT}, {8'h03, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT}, {8'hA6, 1'b0, NO_RESULT}
    };

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    t_byte  i_cfg_data;
    logic   i_in_valid;
    logic   o_in_stall;
    t_byte  i_rx_byte;
    logic   o_out_valid;
    logic   i_out_stall;
    logic   o_command;
    t_byte  o_red;
    t_byte  o_green;
    t_byte  o_blue;
    t_byte  o_white;
    t_byte  o_brightness;
    logic   o_control_held;

    // Framer predictor state
    t_byte   hdr_reg;
    t_count  pkt_count;
    t_byte   pkt_xor;
    t_byte   pkt_bytes [STORE_DEPTH];
    logic    ctrl_flag;
    t_result color_results_q [$];

    int mismatches = 0;
    int words_sent = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    serial_color_command_framer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command      (o_command),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_white        (o_white),
        .o_brightness   (o_brightness),
        .o_control_held (o_control_held)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Level byte biased toward the extremes
    function automatic t_byte pick_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return t_byte'($urandom);
    endfunction

    // Advance the framer by one accepted word and queue the result it yields
    function automatic void frame_word(t_byte word, logic fixed, t_result want);
        t_result got;
        bit      made;
        made = 1'b0;
        got  = NO_RESULT;
        if (pkt_count == '0) begin
            if (word == hdr_reg) begin
                pkt_xor   = word;
                pkt_count = t_count'(1);
            end
        end else if (pkt_count < LAST_IDX) begin
            pkt_bytes[pkt_count - t_count'(1)] = word;
            pkt_xor   = pkt_xor ^ word;
            pkt_count = pkt_count + t_count'(1);
        end else begin
            pkt_count = '0;
            if (word == pkt_xor) begin
                if (pkt_bytes[0] == CMD_SET) begin
                    ctrl_flag      = 1'b1;
                    got.command    = RES_SET;
                    got.red        = pkt_bytes[1];
                    got.green      = pkt_bytes[2];
                    got.blue       = pkt_bytes[3];
                    got.white      = pkt_bytes[4];
                    got.brightness = pkt_bytes[5];
                    made           = 1'b1;
                end else if (pkt_bytes[0] == CMD_RELEASE) begin
                    ctrl_flag   = 1'b0;
                    got.command = RES_RELEASE;
                    made        = 1'b1;
                end
                got.control_held = ctrl_flag;
            end
            pkt_xor = '0;
        end
        if (fixed)
            color_results_q.push_back(want);
        else if (made)
            color_results_q.push_back(got);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %0s: got %02h, expected %02h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Compare one taken result word with the oldest pending one
    task automatic check_color_result();
        t_result want;
        if (color_results_q.size() == 0) begin
            report_mismatch("result word with none pending", 1, 0);
            return;
        end
        want = color_results_q.pop_front();
        if (o_command !== want.command)
            report_mismatch("command", int'(o_command), int'(want.command));
        if (o_red !== want.red)
            report_mismatch("red", int'(o_red), int'(want.red));
        if (o_green !== want.green)
            report_mismatch("green", int'(o_green), int'(want.green));
        if (o_blue !== want.blue)
            report_mismatch("blue", int'(o_blue), int'(want.blue));
        if (o_white !== want.white)
            report_mismatch("white", int'(o_white), int'(want.white));
        if (o_brightness !== want.brightness)
            report_mismatch("brightness", int'(o_brightness), int'(want.brightness));
        if (o_control_held !== want.control_held)
            report_mismatch("control_held", int'(o_control_held),
                            int'(want.control_held));
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(t_byte word, logic fixed, t_result want);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= word;
        do @(posedge i_clk); while (o_in_stall);
        frame_word(word, fixed, want);
        words_sent++;
    endtask

    // Mostly well-formed packets, some noise, bad checksums and unknown commands
    task automatic send_random_frame();
        t_byte frame [PACKET_BYTES];
        int    pick;
        int    n;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(t_byte'($urandom), 1'b0, NO_RESULT);
            return;
        end
        frame[0] = hdr_reg;
        if (pick < 55 || pick >= 84)
            frame[1] = CMD_SET;
        else if (pick < 72)
            frame[1] = CMD_RELEASE;
        else
            frame[1] = t_byte'($urandom);
        for (int k = 2; k < PACKET_BYTES - 1; k++)
            frame[k] = pick_level();
        frame[PACKET_BYTES - 1] = '0;
        for (int k = 0; k < PACKET_BYTES - 1; k++)
            frame[PACKET_BYTES - 1] = frame[PACKET_BYTES - 1] ^ frame[k];
        // corrupt the checksum of some set packets
        if (pick >= 84)
            frame[PACKET_BYTES - 1] = frame[PACKET_BYTES - 1] ^ t_byte'($urandom_range(1, 255));
        foreach (frame[k])
            send_word(frame[k], 1'b0, NO_RESULT);
    endtask

    // Drop valid, wait out all pending results and the pipeline
    task automatic settle();
        i_in_valid <= 1'b0;
        while (color_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(t_byte value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hdr_reg = value;
    endtask

    // Result side: random stalls, long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                check_color_result();
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = steady ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int    phase_start;
        t_byte next_hdr;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        hdr_reg     = HEADER_RESET;
        pkt_count   = '0;
        pkt_xor     = '0;
        ctrl_flag   = 1'b0;
        foreach (pkt_bytes[k]) pkt_bytes[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            // Reprogram the header only with no packet in flight
            if (ph > 0) begin
                settle();
                case (ph)
                    1: next_hdr = 8'h00;
                    2: next_hdr = 8'hFF;
                    3: next_hdr = t_byte'($urandom_range(1, 254));
                    default: next_hdr = HEADER_RESET;
                endcase
                write_header(next_hdr);
            end
            phase_start = words_sent;

            if (ph == 0) begin
                foreach (SCRIPT[i])
                    send_word(SCRIPT[i].word, SCRIPT[i].fixed, SCRIPT[i].want);
                // Hold off the result side while packets keep coming
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (4) begin
                    send_word(hdr_reg, 1'b0, NO_RESULT);
                    send_word(CMD_SET, 1'b0, NO_RESULT);
                    repeat (5) send_word(pick_level(), 1'b0, NO_RESULT);
                    send_word(pkt_xor, 1'b0, NO_RESULT);
                end
                steady = 1'b0;
            end

            while (words_sent - phase_start < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0)
                    steady = !steady;
                send_random_frame();
            end
            // Close any packet that a stray header word opened
            while (pkt_count != '0)
                send_word(pick_level(), 1'b0, NO_RESULT);
        end

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
